### rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin thread scheduler: command
// and status codes, the result record and the ready queue control.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Default number of thread slots.
  localparam int unsigned THREAD_SLOTS_DEF = 16;

  // Quantum register reset value and width.
  localparam int unsigned QUANTUM_W   = 8;
  localparam logic [7:0]  QUANTUM_RST = 8'd10;

  // Width of reported slot numbers.
  localparam int unsigned ID_W = 4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_EXIT   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_FINISHED = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  created_id;
    logic [ID_W-1:0]  running_id;
    logic             switched;
    logic             running_priority;
  } rsp_t;

  // Push and pop requests for the ready queue.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

### rtl/rrts_if.sv
// ----------------------------------------------------------------------------
// rrts_if
// Valid/ready channels of the scheduler: the command channel and the result
// channel.
// ----------------------------------------------------------------------------
interface rrts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       new_priority;

  modport source (output valid, output cmd, output new_priority, input ready);
  modport sink   (input valid, input cmd, input new_priority, output ready);
endinterface

interface rrts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] created_id;
  logic [3:0] running_id;
  logic       switched;
  logic       running_priority;

  modport source (output valid, output status, output created_id, output running_id,
                  output switched, output running_priority, input ready);
  modport sink   (input valid, input status, input created_id, input running_id,
                  input switched, input running_priority, output ready);
endinterface

### rtl/rrts_fifo.sv
// ----------------------------------------------------------------------------
// rrts_fifo
// Ready queue of thread entries. The queue memory has a registered read
// port addressed by the next head pointer, so rdata_o always shows the
// entry at the head, including one written in the cycle before.
// ----------------------------------------------------------------------------
module rrts_fifo #(
  parameter int unsigned DEPTH  = rrts_pkg::THREAD_SLOTS_DEF,
  parameter int unsigned DATA_W = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrts_pkg::fifo_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0]            wdata_i,
  output logic [DATA_W-1:0]            rdata_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LAST) ? '0 : head_q + PTR_W'(1);
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LAST) ? '0 : tail_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(ctrl_i.push) - CNT_W'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
  end

  // A write landing on the new head is forwarded into the read register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (tail_q == head_d)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[head_d];
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

endmodule

### rtl/round_robin_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Round-robin thread scheduler with a time quantum over a table of slots.
//
//   Channel   Dir  Beat contents
//   req_i     in   cmd, new_priority
//   rsp_o     out  status, created_id, running_id, switched, running_priority
//   cfg       in   cfg_we_i / cfg_wdata_i write the quantum in ticks
//
// One command beat is taken every cycle unless the result side stalls; its
// result is registered and shows in the next cycle. The cycle is set by the
// find-first-free encoder over the slot table and the ready queue update,
// both done in one pass. Reset is asynchronous and takes effect at once;
// there is no clearing pass. A stalled result holds the command side only
// when the result register is full and not being taken.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core #(
  parameter int unsigned THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  rrts_req_if.sink         req_i,
  rrts_rsp_if.source       rsp_o
);

  localparam int unsigned SLOT_W = $clog2(THREAD_SLOTS);
  localparam int unsigned CNT_W  = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned QW     = rrts_pkg::QUANTUM_W;
  localparam int unsigned ENT_W  = QW + 1 + SLOT_W;
  localparam int unsigned IDW    = rrts_pkg::ID_W;

  // Running thread context and slot table.
  logic [THREAD_SLOTS-1:0] in_use_q, in_use_d;
  logic [SLOT_W-1:0]       run_slot_q, run_slot_d;
  logic [QW-1:0]           run_ticks_q, run_ticks_d;
  logic                    run_prio_q, run_prio_d;
  logic                    finished_q, finished_d;
  logic [QW-1:0]           quantum_q;

  logic                    rsp_valid_q;
  rrts_pkg::rsp_t          rsp_q, rsp_d;

  rrts_pkg::fifo_ctrl_t    fifo_ctrl;
  logic [ENT_W-1:0]        fifo_wdata;
  logic [ENT_W-1:0]        fifo_rdata;
  logic [CNT_W-1:0]        fifo_count;

  logic [SLOT_W-1:0]       hd_slot;
  logic                    hd_prio;
  logic [QW-1:0]           hd_ticks;
  logic [SLOT_W-1:0]       free_idx;
  logic                    free_found;
  logic [QW-1:0]           ticks_dec;
  logic                    accept;
  logic                    switched;
  logic                    full;
  logic [SLOT_W-1:0]       created_slot;
  logic [SLOT_W+IDW-1:0]   created_ext;
  logic [SLOT_W+IDW-1:0]   running_ext;
  rrts_pkg::cmd_e          cmd;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cmd         = rrts_pkg::cmd_e'(req_i.cmd);

  // Ready queue entries carry the slot with its remaining ticks and priority.
  assign hd_slot  = fifo_rdata[SLOT_W-1:0];
  assign hd_prio  = fifo_rdata[SLOT_W];
  assign hd_ticks = fifo_rdata[ENT_W-1:SLOT_W+1];

  assign ticks_dec = run_ticks_q - QW'(1);

  // Lowest free slot.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    in_use_d      = in_use_q;
    run_slot_d    = run_slot_q;
    run_ticks_d   = run_ticks_q;
    run_prio_d    = run_prio_q;
    finished_d    = finished_q;
    fifo_ctrl     = '0;
    fifo_wdata    = {quantum_q, run_prio_q, run_slot_q};
    switched      = 1'b0;
    full          = 1'b0;
    created_slot  = '0;

    if (accept && !finished_q) begin
      case (cmd)
        rrts_pkg::CMD_TICK: begin
          if (ticks_dec == '0) begin
            run_ticks_d = quantum_q;
            if (fifo_count != '0) begin
              // Preempt: current thread to the back with a fresh quantum.
              fifo_ctrl.pop  = 1'b1;
              fifo_ctrl.push = 1'b1;
              run_slot_d     = hd_slot;
              run_prio_d     = hd_prio;
              run_ticks_d    = hd_ticks;
              switched       = 1'b1;
            end
          end else begin
            run_ticks_d = ticks_dec;
          end
        end
        rrts_pkg::CMD_CREATE: begin
          if (!free_found) begin
            full = 1'b1;
          end else begin
            in_use_d[free_idx] = 1'b1;
            fifo_ctrl.push     = 1'b1;
            fifo_wdata         = {quantum_q, req_i.new_priority, free_idx};
            created_slot       = free_idx;
          end
        end
        rrts_pkg::CMD_EXIT: begin
          in_use_d[run_slot_q] = 1'b0;
          if (fifo_count != '0) begin
            fifo_ctrl.pop = 1'b1;
            run_slot_d    = hd_slot;
            run_prio_d    = hd_prio;
            run_ticks_d   = hd_ticks;
            switched      = 1'b1;
          end else begin
            finished_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign created_ext = {{IDW{1'b0}}, created_slot};
  assign running_ext = {{IDW{1'b0}}, run_slot_d};

  always_comb begin
    if (finished_d) begin
      rsp_d = '{status: rrts_pkg::STATUS_FINISHED, created_id: '0, running_id: '0,
                switched: 1'b0, running_priority: 1'b0};
    end else begin
      rsp_d.status           = full ? rrts_pkg::STATUS_FULL : rrts_pkg::STATUS_OK;
      rsp_d.created_id       = created_ext[IDW-1:0];
      rsp_d.running_id       = running_ext[IDW-1:0];
      rsp_d.switched         = switched;
      rsp_d.running_priority = run_prio_d;
    end
  end

  rrts_fifo #(
    .DEPTH  (THREAD_SLOTS),
    .DATA_W (ENT_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i (fifo_wdata),
    .rdata_o (fifo_rdata),
    .count_o (fifo_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= THREAD_SLOTS'(1);
      run_slot_q  <= '0;
      run_ticks_q <= rrts_pkg::QUANTUM_RST;
      run_prio_q  <= 1'b0;
      finished_q  <= 1'b0;
      quantum_q   <= rrts_pkg::QUANTUM_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      in_use_q    <= in_use_d;
      run_slot_q  <= run_slot_d;
      run_ticks_q <= run_ticks_d;
      run_prio_q  <= run_prio_d;
      finished_q  <= finished_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_q.status;
  assign rsp_o.created_id       = rsp_q.created_id;
  assign rsp_o.running_id       = rsp_q.running_id;
  assign rsp_o.switched         = rsp_q.switched;
  assign rsp_o.running_priority = rsp_q.running_priority;

endmodule

### rtl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] status,
  input logic [3:0] created_id,
  input logic [3:0] running_id,
  input logic       switched,
  input logic       running_priority
);

  logic seen_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fin_q <= 1'b0;
    end else if (rsp_valid && rsp_ready && (status == rrts_pkg::STATUS_FINISHED)) begin
      seen_fin_q <= 1'b1;
    end
  end

  // Once all threads have finished, every later beat says so.
  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && seen_fin_q |-> status == rrts_pkg::STATUS_FINISHED)
    else $error("finished state was left");

  a_finished_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status == rrts_pkg::STATUS_FINISHED) |->
      created_id == 4'd0 && running_id == 4'd0 && !switched && !running_priority)
    else $error("finished beat carries nonzero fields");

  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status == rrts_pkg::STATUS_FULL) |-> created_id == 4'd0 && !switched)
    else $error("full beat reports a creation or a switch");

  // An empty result register never holds back commands.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid |-> req_ready)
    else $error("commands stalled with no pending result");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(running_id))
    else $error("stalled result changed");

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_ready        (req_i.ready),
  .rsp_valid        (rsp_o.valid),
  .rsp_ready        (rsp_o.ready),
  .status           (rsp_o.status),
  .created_id       (rsp_o.created_id),
  .running_id       (rsp_o.running_id),
  .switched         (rsp_o.switched),
  .running_priority (rsp_o.running_priority)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin thread scheduler. A short table of
// commands walks reset state, table full, slot reuse and the unused command
// code. Random phases follow under several quantum settings, ending in the
// sticky finished state. Every result beat is compared with a software copy
// of the scheduler, or with the table's value for a typed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = rrts_pkg::THREAD_SLOTS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct {
    logic [1:0]     cmd;
    logic           prio;
    bit             typed;
    rrts_pkg::rsp_t want;
  } cmd_row_t;

  typedef struct {
    bit          write_q;
    logic [7:0]  q;
    int unsigned items;
    int unsigned tick_pct;
    int unsigned idle;
    bit          hold;
  } phase_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  rrts_req_if req_if ();
  rrts_rsp_if rsp_if ();

  round_robin_thread_scheduler_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Software copy of the scheduler state.
  logic [7:0]  quantum;
  logic        slot_busy [SLOTS];
  logic [7:0]  slot_ticks [SLOTS];
  logic        slot_prio [SLOTS];
  logic [3:0]  run_queue [SLOTS];
  int unsigned rq_head;
  int unsigned rq_tail;
  int unsigned rq_count;
  int unsigned running;
  bit          done;

  rrts_pkg::rsp_t schedule_outcomes[$];
  int unsigned    errors;
  int unsigned    idle_mode;
  bit             hold_rsp;

  cmd_row_t opening_rows [] = '{
    '{rrts_pkg::CMD_TICK,   1'b0, 1'b1, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{CMD_UNUSED,           1'b1, 1'b1, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b1, '{rrts_pkg::STATUS_OK, 4'd1, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b1, '{rrts_pkg::STATUS_OK, 4'd2, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    // Slot table is now full.
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b1, '{rrts_pkg::STATUS_FULL, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_EXIT,   1'b0, 1'b1, '{rrts_pkg::STATUS_OK, 4'd0, 4'd1, 1'b1, 1'b1}},
    // The freed slot 0 is the lowest free one again.
    '{rrts_pkg::CMD_CREATE, 1'b0, 1'b1, '{rrts_pkg::STATUS_OK, 4'd0, 4'd1, 1'b0, 1'b1}},
    '{rrts_pkg::CMD_TICK,   1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}},
    '{rrts_pkg::CMD_CREATE, 1'b1, 1'b1, '{rrts_pkg::STATUS_FULL, 4'd0, 4'd1, 1'b0, 1'b1}},
    '{rrts_pkg::CMD_EXIT,   1'b1, 1'b0, '{rrts_pkg::STATUS_OK, 4'd0, 4'd0, 1'b0, 1'b0}}
  };

  phase_t plan [6] = '{
    '{1'b0, 8'd10,  60,  45, 1, 1'b0},
    '{1'b1, 8'd1,   80,  45, 0, 1'b1},
    '{1'b1, 8'd255, 40,  40, 2, 1'b0},
    '{1'b1, 8'd2,   70,  50, 1, 1'b0},
    '{1'b1, 8'd0,   270, 97, 0, 1'b0},
    '{1'b1, 8'd5,   50,  50, 2, 1'b0}
  };

  always #2 clk = ~clk;

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  function automatic int unsigned draw_gap();
    case (idle_mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic void rq_push(int unsigned slot);
    if (rq_count >= SLOTS) return;
    run_queue[rq_tail] = slot[3:0];
    rq_tail = (rq_tail + 1) % SLOTS;
    rq_count++;
  endfunction

  function automatic int unsigned rq_pop();
    int unsigned slot;
    slot = run_queue[rq_head];
    rq_head = (rq_head + 1) % SLOTS;
    rq_count--;
    return slot;
  endfunction

  function automatic rrts_pkg::rsp_t advance_scheduler(logic [1:0] cmd, logic prio);
    rrts_pkg::rsp_t r;
    int unsigned    nxt;
    int             free_slot;
    r.status = rrts_pkg::STATUS_OK;
    r.created_id = '0;
    r.switched = 1'b0;
    if (!done) begin
      case (cmd)
        rrts_pkg::CMD_TICK: begin
          slot_ticks[running] = slot_ticks[running] - 8'd1;
          if (slot_ticks[running] == 8'd0) begin
            slot_ticks[running] = quantum;
            if (rq_count != 0) begin
              nxt = rq_pop();
              rq_push(running);
              running = nxt;
              r.switched = 1'b1;
            end
          end
        end
        rrts_pkg::CMD_CREATE: begin
          free_slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_busy[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            r.status = rrts_pkg::STATUS_FULL;
          end else begin
            slot_busy[free_slot] = 1'b1;
            slot_prio[free_slot] = prio;
            slot_ticks[free_slot] = quantum;
            rq_push(free_slot);
            r.created_id = free_slot[3:0];
          end
        end
        rrts_pkg::CMD_EXIT: begin
          slot_busy[running] = 1'b0;
          if (rq_count != 0) begin
            running = rq_pop();
            r.switched = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (done) begin
      r.status = rrts_pkg::STATUS_FINISHED;
      r.created_id = '0;
      r.running_id = '0;
      r.switched = 1'b0;
      r.running_priority = 1'b0;
    end else begin
      r.running_id = running[3:0];
      r.running_priority = slot_prio[running];
    end
    return r;
  endfunction

  // Offers one command beat and records what the scheduler should answer.
  // A typed row overrides the computed answer with the value from the table.
  task automatic send_cmd(logic [1:0] cmd, logic prio, bit typed, rrts_pkg::rsp_t want);
    int unsigned    gap;
    rrts_pkg::rsp_t predicted;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.cmd = cmd;
    req_if.new_priority = prio;
    do @(posedge clk); while (!req_if.ready);
    predicted = advance_scheduler(cmd, prio);
    schedule_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic set_quantum(logic [7:0] q);
    @(negedge clk);
    req_if.valid = 1'b0;
    while (schedule_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = q;
    quantum = q;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [1:0] draw_cmd(int unsigned tick_pct);
    int unsigned roll;
    logic [1:0]  cmd;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      cmd = rrts_pkg::CMD_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) cmd = rrts_pkg::CMD_CREATE;
      else if (roll < 88) cmd = rrts_pkg::CMD_EXIT;
      else cmd = CMD_UNUSED;
    end
    // Keep the scheduler alive until the closing phase.
    if (cmd == rrts_pkg::CMD_EXIT && rq_count == 0) cmd = rrts_pkg::CMD_TICK;
    return cmd;
  endfunction

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    rrts_pkg::rsp_t want;
    int unsigned    gap;
    @(posedge rst_n);
    forever begin
      gap = hold_rsp ? HOLD_CYCLES : draw_gap();
      hold_rsp = 1'b0;
      @(negedge clk);
      if (gap > 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (schedule_outcomes.size() == 0) begin
        report_mismatch("unexpected beat, status", int'(rsp_if.status), -1);
      end else begin
        want = schedule_outcomes.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", int'(rsp_if.status), int'(want.status));
        if (rsp_if.created_id !== want.created_id)
          report_mismatch("created_id", int'(rsp_if.created_id), int'(want.created_id));
        if (rsp_if.running_id !== want.running_id)
          report_mismatch("running_id", int'(rsp_if.running_id), int'(want.running_id));
        if (rsp_if.switched !== want.switched)
          report_mismatch("switched", int'(rsp_if.switched), int'(want.switched));
        if (rsp_if.running_priority !== want.running_priority)
          report_mismatch("running_priority", int'(rsp_if.running_priority),
                          int'(want.running_priority));
      end
    end
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rrts_pkg::rsp_t no_want;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.cmd = rrts_pkg::CMD_TICK;
    req_if.new_priority = 1'b0;
    rsp_if.ready = 1'b0;
    errors = 0;
    idle_mode = 1;
    hold_rsp = 1'b0;
    no_want = '0;

    quantum = rrts_pkg::QUANTUM_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_ticks[i] = '0;
      slot_prio[i] = 1'b0;
      run_queue[i] = '0;
    end
    slot_busy[0] = 1'b1;
    slot_ticks[0] = rrts_pkg::QUANTUM_RST;
    rq_head = 0;
    rq_tail = 0;
    rq_count = 0;
    running = 0;
    done = 1'b0;
    plan[5].q = 8'($urandom_range(3, 12));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (opening_rows[i])
      send_cmd(opening_rows[i].cmd, opening_rows[i].prio, opening_rows[i].typed,
               opening_rows[i].want);

    foreach (plan[p]) begin
      if (plan[p].write_q) set_quantum(plan[p].q);
      idle_mode = plan[p].idle;
      // The sender keeps offering back to back while results are held off.
      if (plan[p].hold) hold_rsp = 1'b1;
      repeat (plan[p].items)
        send_cmd(draw_cmd(plan[p].tick_pct), 1'($urandom_range(0, 1)), 1'b0, no_want);
    end

    // Drain every thread; the last exit enters the sticky finished state.
    idle_mode = 1;
    while (!done) send_cmd(rrts_pkg::CMD_EXIT, 1'($urandom_range(0, 1)), 1'b0, no_want);
    for (int i = 0; i < 8; i++)
      send_cmd(2'(i % 4), 1'($urandom_range(0, 1)), 1'b0, no_want);

    @(negedge clk);
    req_if.valid = 1'b0;
    while (schedule_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_fifo.sv
rtl/round_robin_thread_scheduler_core.sv
rtl/rrts_checker.sv
tb/testbench.sv
